FILE: design/assert_macros.svh
// Assertion helper macros shared by the decoder sources.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("fail");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

FILE: design/vt100_pkg.sv
// ----------------------------------------------------------------------------
// vt100_pkg: shared types and constants
// Parse states, sequencer states, command codes and color palette.
// ----------------------------------------------------------------------------
package vt100_pkg;
  typedef enum logic [2:0] {
    PS_IDLE = 3'd0, PS_ESC = 3'd1, PS_CSI = 3'd2, PS_PRIV = 3'd3,
    PS_ARG = 3'd4, PS_SKIP = 3'd5
  } parse_t;
  typedef enum logic [1:0] {
    SQ_IDLE, SQ_WORK, SQ_OUT
  } seq_t;
  localparam logic [1:0] OP_PUT  = 2'd0;
  localparam logic [1:0] OP_SPAN = 2'd1;
  localparam logic [1:0] OP_ROWS = 2'd2;
  localparam logic CFG_COLUMNS = 1'b0;
  localparam logic CFG_ROWS    = 1'b1;
  // tab stop pitch, a power of two
  localparam int TAB_PITCH = 4;
  localparam logic [7:0] KEY_ESC = 8'h1b;
  localparam logic [7:0] KEY_DEL = 8'h7f;
  localparam logic [7:0] KEY_SPACE = 8'h20;
  localparam logic [15:0] COLOR_FG_RESET = 16'hffff;
  localparam logic [15:0] COLOR_BG_RESET = 16'h0000;
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] col;
    logic [7:0] col_end;
    logic [7:0] row;
    logic [7:0] row_end;
    logic [7:0] glyph;
  } cmd_t;
  function automatic logic [15:0] palette(input logic [2:0] i);
    logic [15:0] p;
    begin
      case (i)
        3'd0: p = 16'h0000;
        3'd1: p = 16'hf800;
        3'd2: p = 16'h0780;
        3'd3: p = 16'hfe00;
        3'd4: p = 16'h001f;
        3'd5: p = 16'hf81f;
        3'd6: p = 16'h07ff;
        default: p = 16'hffff;
      endcase
      return p;
    end
  endfunction
endpackage

FILE: design/vt100_outq.sv
// ----------------------------------------------------------------------------
// vt100_outq: output word register
// Holds one display command until the consumer takes it.
// ----------------------------------------------------------------------------
module vt100_outq import vt100_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  cmd_t        cmd_in,
  input  logic [15:0] fg_in,
  input  logic [15:0] bg_in,
  input  logic        last_in,
  output logic        busy,
  output logic        out_valid,
  input  logic        out_ready,
  output cmd_t        cmd_out,
  output logic [15:0] fg_out,
  output logic [15:0] bg_out,
  output logic        last_out
);
  // hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (load) begin
      cmd_out <= cmd_in; fg_out <= fg_in; bg_out <= bg_in; last_out <= last_in;
    end
  end
  assign busy = out_valid && !out_ready;
endmodule

FILE: design/vt100_escape_decoder_core.sv
// ----------------------------------------------------------------------------
// vt100_escape_decoder_core: VT100 escape decoder core
// One byte is taken when ready is high; a small sequencer then runs its
// steps through one shared cursor unit, emitting up to four commands, each
// one output word. A printed character is first prepared as a put and then
// loaded into the output register; a tab emits up to four puts, and a color
// command walks its arguments one per cycle. A held-off output stalls the
// sequencer. The block is not ready while a byte is being worked on.
// ----------------------------------------------------------------------------
module vt100_escape_decoder_core import vt100_pkg::*; #(
  parameter int MAX_ARGS = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        valid,
  output logic        ready,
  input  logic [7:0]  ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  op,
  output logic [7:0]  col,
  output logic [7:0]  col_end,
  output logic [7:0]  row,
  output logic [7:0]  row_end,
  output logic [7:0]  glyph,
  output logic [15:0] fg,
  output logic [15:0] bg,
  output logic        last
);
  `include "assert_macros.svh"
  localparam int AW = $clog2(MAX_ARGS + 1);
  localparam int IW = $clog2(MAX_ARGS);

  logic [7:0] columns, rows;
  parse_t pstate;
  logic priv_ret;
  logic [15:0] args [MAX_ARGS];
  logic [AW-1:0] argc;
  logic [7:0] cur_c, cur_r, sav_c, sav_r, mtop, mbot;
  logic [15:0] fcol, bcol;
  logic wrap_on, origin_on;

  seq_t sq, sq_next;
  logic [7:0] byte_q;
  logic [2:0] puts_left;   // remaining character or tab puts
  logic [AW-1:0] sgr_i;    // SGR walk index
  logic pend;              // a command waits to be pushed
  cmd_t pcmd;
  logic busy;

  // derived sizes
  logic [7:0] nc, nr, cmax, rmax, rtop, rbot;
  assign nc = (columns == 8'd0) ? 8'd1 : columns;
  assign nr = (rows == 8'd0) ? 8'd1 : rows;
  assign cmax = nc - 8'd1;
  assign rmax = nr - 8'd1;
  always_comb begin
    logic [7:0] b;
    b = (mbot > nr) ? nr : mbot;
    if (mtop >= b) begin
      rtop = 8'd0; rbot = nr;
    end else begin
      rtop = mtop; rbot = b;
    end
  end
  logic [7:0] cc, cr;
  assign cc = (cur_c > cmax) ? cmax : cur_c;
  assign cr = (cur_r > rmax) ? rmax : cur_r;

  // shared vertical move unit
  function automatic logic [7:0] vdown(input logic [7:0] r, input logic [7:0] bot,
                                       input logic [7:0] mx);
    logic [8:0] ny;
    begin
      ny = {1'b0, r} + 9'd1;
      if (r < bot && ny >= {1'b0, bot}) ny = {1'b0, bot} - 9'd1;
      if (ny > {1'b0, mx}) ny = {1'b0, mx};
      return ny[7:0];
    end
  endfunction
  function automatic logic [7:0] vup(input logic [7:0] r, input logic [7:0] top);
    logic [7:0] ny;
    begin
      ny = (r == 8'd0) ? 8'd0 : r - 8'd1;
      if (r >= top && r < top + 8'd0 + 8'd1 && r != 8'd0) ny = top;
      if (r >= top && r == top) ny = top;
      return ny;
    end
  endfunction

  logic [15:0] a0, a1, n;
  assign a0 = args[0];
  assign a1 = args[1];
  assign n  = (a0 == 16'd0) ? 16'd1 : a0;
  logic is_dig;
  assign is_dig = byte_q >= "0" && byte_q <= "9";

  assign ready = (sq == SQ_IDLE);
  logic accept;
  assign accept = valid && ready;

  // next sequencer state
  always_comb begin
    sq_next = sq;
    unique case (sq)
      SQ_IDLE: if (accept) sq_next = SQ_WORK;
      SQ_WORK: sq_next = SQ_OUT;
      SQ_OUT: begin
        if (!pend && puts_left == 3'd0 && sgr_i == '0) sq_next = SQ_IDLE;
        else if (!pend && !busy) sq_next = SQ_OUT;
      end
      default: sq_next = SQ_IDLE;
    endcase
  end
  always_ff @(posedge clk) begin
    if (rst) sq <= SQ_IDLE;
    else sq <= sq_next;
  end

  // push the pending word when the output register frees
  logic push;
  assign push = (sq == SQ_OUT) && pend && !busy;
  logic more;
  assign more = (puts_left != 3'd0) || (sgr_i != '0);

  vt100_outq u_outq (
    .clk(clk), .rst(rst), .load(push), .cmd_in(pcmd), .fg_in(fcol), .bg_in(bcol),
    .last_in(!more), .busy(busy), .out_valid(out_valid), .out_ready(out_ready),
    .cmd_out({op, col, col_end, row, row_end, glyph}), .fg_out(fg), .bg_out(bg),
    .last_out(last)
  );

  // build a put command at the given cell
  function automatic cmd_t put_cmd(input logic [7:0] c, input logic [7:0] r,
                                   input logic [7:0] g);
    cmd_t k;
    begin
      k.op = OP_PUT; k.col = c; k.col_end = c; k.row = r; k.row_end = r; k.glyph = g;
      return k;
    end
  endfunction

  // main datapath
  always_ff @(posedge clk) begin
    logic [19:0] t;
    logic [15:0] v;
    logic [7:0] nc2, nr2, e8;
    logic done;
    if (rst) begin
      columns <= 8'd80; rows <= 8'd24;
      pstate <= PS_IDLE; priv_ret <= 1'b0; argc <= '0;
      for (int i = 0; i < MAX_ARGS; i++) args[i] <= 16'd0;
      cur_c <= '0; cur_r <= '0; sav_c <= '0; sav_r <= '0;
      fcol <= COLOR_FG_RESET; bcol <= COLOR_BG_RESET;
      mtop <= '0; mbot <= 8'd24; wrap_on <= 1'b1; origin_on <= 1'b0;
      pend <= 1'b0; puts_left <= '0; sgr_i <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_COLUMNS) columns <= cfg_data;
        else rows <= cfg_data;
      end
      if (accept) byte_q <= ch;
      if (push) pend <= 1'b0;
      if (sq == SQ_WORK) begin
        cur_c <= cc; cur_r <= cr;
        unique case (pstate)
          PS_ESC: begin
            pstate <= PS_IDLE;
            case (byte_q)
              "[": begin
                for (int i = 0; i < MAX_ARGS; i++) args[i] <= 16'd0;
                argc <= '0; pstate <= PS_CSI;
              end
              "(", ")", "#": begin
                for (int i = 0; i < MAX_ARGS; i++) args[i] <= 16'd0;
                argc <= '0; pstate <= PS_SKIP;
              end
              "D": cur_r <= vdown(cr, rbot, rmax);
              "M": cur_r <= vup(cr, rtop);
              "E": begin cur_r <= vdown(cr, rbot, rmax); cur_c <= '0; end
              "7", "s": begin sav_c <= cc; sav_r <= cr; end
              "8", "u": begin
                cur_c <= (sav_c > cmax) ? cmax : sav_c;
                cur_r <= (sav_r > rmax) ? rmax : sav_r;
              end
              "c": begin
                priv_ret <= 1'b0; argc <= '0;
                for (int i = 0; i < MAX_ARGS; i++) args[i] <= 16'd0;
                cur_c <= '0; cur_r <= '0; sav_c <= '0; sav_r <= '0;
                fcol <= COLOR_FG_RESET; bcol <= COLOR_BG_RESET;
                mtop <= '0; mbot <= nr; wrap_on <= 1'b1; origin_on <= 1'b0;
              end
              KEY_ESC: pstate <= PS_ESC;
              default: ;
            endcase
          end
          PS_SKIP: pstate <= PS_IDLE;
          PS_CSI, PS_PRIV, PS_ARG: begin
            done = 1'b0;
            if (is_dig) begin
              if (pstate != PS_ARG) priv_ret <= (pstate == PS_PRIV);
              pstate <= PS_ARG;
              if (argc < AW'(MAX_ARGS)) begin
                t = 20'(args[argc[IW-1:0]]) * 20'd10 + 20'(byte_q - "0");
                args[argc[IW-1:0]] <= (t > 20'd65535) ? 16'hffff : t[15:0];
              end
              done = 1'b1;
            end
            if (!done && pstate == PS_ARG && argc < AW'(MAX_ARGS)) argc <= argc + 1'b1;
            if (!done && byte_q != ";") begin
              if ((pstate == PS_PRIV) || (pstate == PS_ARG && priv_ret)) begin
                pstate <= PS_IDLE;
                if (byte_q == "h" || byte_q == "l") begin
                  if (a0 == 16'd6) origin_on <= (byte_q == "h");
                  else if (a0 == 16'd7) wrap_on <= (byte_q == "h");
                end
              end else begin
                // final argument count seen by the command
                logic [AW-1:0] ac;
                ac = (pstate == PS_ARG && argc < AW'(MAX_ARGS)) ? argc + 1'b1 : argc;
                pstate <= PS_IDLE;
                case (byte_q)
                  "A": cur_r <= (16'(cr) > n) ? cr - n[7:0] : 8'd0;
                  "B": cur_r <= (n > 16'(rmax - cr)) ? rmax : cr + n[7:0];
                  "C": cur_c <= (n > 16'(cmax - cc)) ? cmax : cc + n[7:0];
                  "D": cur_c <= (16'(cc) > n) ? cc - n[7:0] : 8'd0;
                  "H", "f": begin
                    t = 20'(n) - 20'd1;
                    if (origin_on) begin
                      t = t + 20'(rtop);
                      if (t >= 20'(rbot)) t = 20'(rbot) - 20'd1;
                    end
                    cur_r <= (t > 20'(rmax)) ? rmax : t[7:0];
                    v = ((a1 == 16'd0) ? 16'd1 : a1) - 16'd1;
                    cur_c <= (v > 16'(cmax)) ? cmax : v[7:0];
                  end
                  "J": begin
                    pcmd.op <= OP_ROWS; pcmd.col <= '0; pcmd.col_end <= cmax;
                    pcmd.glyph <= KEY_SPACE;
                    pcmd.row <= (a0 == 16'd0) ? cr : 8'd0;
                    pcmd.row_end <= (a0 == 16'd1) ? cr : rmax;
                    pend <= (a0 <= 16'd2);
                  end
                  "K": begin
                    pcmd.op <= OP_SPAN; pcmd.row <= cr; pcmd.row_end <= cr;
                    pcmd.glyph <= KEY_SPACE;
                    pcmd.col <= (a0 == 16'd0) ? cc : 8'd0;
                    pcmd.col_end <= (a0 == 16'd1) ? cc : cmax;
                    pend <= (a0 <= 16'd2);
                  end
                  "P": begin
                    t = 20'(cc) + 20'(n) - 20'd1;
                    pcmd.op <= OP_SPAN; pcmd.row <= cr; pcmd.row_end <= cr;
                    pcmd.glyph <= KEY_SPACE; pcmd.col <= cc;
                    pcmd.col_end <= (t > 20'(cmax)) ? cmax : t[7:0];
                    pend <= 1'b1;
                  end
                  "m": begin
                    if (ac == '0) begin
                      fcol <= COLOR_FG_RESET; bcol <= COLOR_BG_RESET;
                    end else sgr_i <= ac;
                  end
                  "r": if (ac == AW'(2)) begin
                    v = (a1 > 16'(nr)) ? 16'(nr) : a1;
                    if (n < v) begin mtop <= n[7:0] - 8'd1; mbot <= v[7:0]; end
                  end
                  "s": begin sav_c <= cc; sav_r <= cr; end
                  "u": begin
                    cur_c <= (sav_c > cmax) ? cmax : sav_c;
                    cur_r <= (sav_r > rmax) ? rmax : sav_r;
                  end
                  "?": pstate <= PS_PRIV;
                  default: ;
                endcase
              end
            end
          end
          default: begin
            pstate <= PS_IDLE;
            case (byte_q)
              8'h05, 8'h07: ;
              8'h0a: begin cur_r <= vdown(cr, rbot, rmax); cur_c <= '0; end
              8'h0d: cur_c <= '0;
              8'h08: if (cc != 8'd0) cur_c <= cc - 8'd1;
              KEY_ESC: pstate <= PS_ESC;
              8'h09: begin
                // the pitch is a power of two, so a mask gives the offset
                t = 20'(TAB_PITCH) - 20'(cc & 8'(TAB_PITCH - 1));
                puts_left <= (t > 20'd4) ? 3'd4 : t[2:0];
              end
              default: puts_left <= 3'd1;
            endcase
          end
        endcase
      end
      // one put per step through the cursor advance unit
      if (sq == SQ_OUT && !pend && puts_left != 3'd0) begin
        pcmd <= put_cmd(cur_c, cur_r,
                        (byte_q == 8'h09 || byte_q == KEY_DEL) ? KEY_SPACE : byte_q);
        pend <= 1'b1;
        puts_left <= puts_left - 3'd1;
        nc2 = cur_c; nr2 = cur_r;
        if (cur_c + 8'd1 >= nc || cur_c == 8'hff) begin
          if (wrap_on) begin nc2 = '0; nr2 = vdown(cur_r, rbot, rmax); end
          else nc2 = cmax;
        end else nc2 = cur_c + 8'd1;
        if (byte_q == KEY_DEL && nc2 != 8'd0) nc2 = nc2 - 8'd1;
        cur_c <= nc2; cur_r <= nr2;
      end
      // walk color arguments last to first
      if (sq == SQ_OUT && sgr_i != '0) begin
        v = args[IW'(sgr_i - 1'b1)];
        e8 = v[7:0];
        if (v == 16'd0) begin fcol <= COLOR_FG_RESET; bcol <= COLOR_BG_RESET; end
        if (v >= 16'd30 && v < 16'd38) fcol <= palette(3'(e8 - 8'd30));
        else if (v >= 16'd40 && v < 16'd48) bcol <= palette(3'(e8 - 8'd40));
        sgr_i <= sgr_i - 1'b1;
      end
    end
  end

  `ASSERT_IMPLY(a_push_free, clk, rst, push, !busy)
  `ASSERT_IMPLY(a_ready_no_pend, clk, rst, ready, !pend)
  `ASSERT_NEXT(a_accept_work, clk, rst, accept, sq == SQ_WORK)
endmodule
